FILE: design/ifa_pkg.sv
// Package for the integer to ASCII formatter.
// Types, character codes and digit helpers shared by the formatter modules.
// No dependencies.
package ifa_pkg;

    localparam int VALUE_W   = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W     = 4 * BCD_DIGITS;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 6;

    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE        = 8'h31;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LOWER_B    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LOWER_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOWER_D    = 8'h64;
    localparam logic [CHAR_W-1:0] CH_ALPHA_BASE = 8'h37;   // 'A' - 10

    localparam logic [POS_W-1:0] POS_LAST_BIN = 6'd31;
    localparam logic [POS_W-1:0] POS_LAST_HEX = 6'd7;
    localparam logic [POS_W-1:0] POS_LAST_DEC = 6'd9;
    localparam logic [POS_W-1:0] POS_HEX_LAST_BYTE = 6'd6;
    localparam logic [POS_W-1:0] BCD_LAST_SHIFT = 6'd31;

    typedef enum logic [1:0] {
        KIND_BIN = 2'd0,
        KIND_HEX = 2'd1,
        KIND_DEC = 2'd2,
        KIND_RAW = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_PFX0,
        S_PFX1,
        S_DIGIT,
        S_RAW,
        S_NUL
    } t_state;

    function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] n);
        logic [CHAR_W-1:0] ext;
        ext = {4'h0, n};
        return (n <= 4'd9) ? (ext + CH_ZERO) : (ext + CH_ALPHA_BASE);
    endfunction

endpackage

FILE: design/ifa_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on ifa_pkg.
module ifa_bcd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ifa_pkg::VALUE_W-1:0] i_bin,
    output logic                        o_done,
    output logic [ifa_pkg::BCD_W-1:0]   o_bcd
);
    import ifa_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   w_adj;
    logic [POS_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            w_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? (r_bcd[4*k +: 4] + 4'd3)
                                                        : r_bcd[4*k +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == BCD_LAST_SHIFT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("bcd done without conversion");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("bcd start did not begin conversion");
`endif

endmodule

FILE: design/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
// Depends on ifa_pkg and ifa_bcd.
//
// Usage:
//   Input channel (i_valid/o_ready) takes one transaction: a signed 32-bit
//   value, a format (binary, hex, decimal, raw byte) and a prefix flag.
//   Output channel (o_valid/i_ready) returns ASCII characters, one per
//   transaction: optional '-', optional 0b/0x/0d, digits or the raw byte,
//   then a NUL carrying o_last.
//   Digits leave a shift register MSB first, one bit (binary) or one
//   nibble (hex, decimal) per cycle while the output is not stalled;
//   suppressed leading positions are still stepped through. Steps per
//   input: accept, sign, two prefix characters if asked for (not raw),
//   digit positions (32 binary, 8 hex, 10 decimal, 1 raw), then NUL;
//   decimal adds a serial BCD conversion before the sign. A '-' leaves
//   first, then a prefix; otherwise the first digit waits out the
//   suppressed ones. o_ready is high only between runs; one output
//   register decouples the receiver, and a stall on i_ready holds the
//   run at its next character to send until it clears.
//   Synchronous reset drops any run in progress and the pending output.
module integer_to_ascii_formatter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ifa_pkg::VALUE_W-1:0]  i_value,
    input  logic [1:0]                          i_kind,
    input  logic                                i_with_prefix,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ifa_pkg::CHAR_W-1:0]          o_character,
    output logic                                o_last
);
    import ifa_pkg::*;

    t_state              r_state, n_state;
    t_kind               r_kind;
    logic                r_neg;
    logic                r_prefix;
    logic                r_seen;
    logic [POS_W-1:0]    r_pos;
    logic [BCD_W-1:0]    r_sh;

    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    logic [VALUE_W-1:0]  w_raw;
    logic [VALUE_W-1:0]  w_mag;
    logic                w_accept;
    logic                w_out_free;
    logic                w_emit;
    logic                w_fire;
    logic [CHAR_W-1:0]   w_char;
    logic                w_last;
    logic                w_adv;
    logic                w_dig_emit;
    logic [CHAR_W-1:0]   w_dig_char;
    logic [POS_W-1:0]    w_pos_last;
    logic [CHAR_W-1:0]   w_pfx_char;
    t_state              w_after_sign;

    logic                w_bcd_start;
    logic                w_bcd_done;
    logic [BCD_W-1:0]    w_bcd;

    assign w_raw    = $unsigned(i_value);
    assign w_mag    = w_raw[VALUE_W-1] ? (~w_raw + 1'b1) : w_raw;
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_bcd_start = w_accept && (t_kind'(i_kind) == KIND_DEC);
    assign w_out_free  = !r_out_valid || i_ready;

    ifa_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_bcd_start),
        .i_bin   (w_mag),
        .o_done  (w_bcd_done),
        .o_bcd   (w_bcd)
    );

    // digit position decode
    always_comb begin
        w_pos_last = POS_LAST_DEC;
        w_dig_emit = 1'b0;
        w_dig_char = CH_ZERO;
        w_pfx_char = CH_LOWER_D;
        case (r_kind)
            KIND_BIN: begin
                w_pos_last = POS_LAST_BIN;
                w_dig_emit = r_seen || r_sh[BCD_W-1] || (r_pos == POS_LAST_BIN);
                w_dig_char = r_sh[BCD_W-1] ? CH_ONE : CH_ZERO;
                w_pfx_char = CH_LOWER_B;
            end
            KIND_HEX: begin
                w_pos_last = POS_LAST_HEX;
                w_dig_emit = r_seen || (!r_pos[0] && (|r_sh[BCD_W-1 -: 8]))
                             || (r_pos >= POS_HEX_LAST_BYTE);
                w_dig_char = nibble_char(r_sh[BCD_W-1 -: 4]);
                w_pfx_char = CH_LOWER_X;
            end
            default: begin
                w_dig_emit = r_seen || (|r_sh[BCD_W-1 -: 4]) || (r_pos == POS_LAST_DEC);
                w_dig_char = nibble_char(r_sh[BCD_W-1 -: 4]);
            end
        endcase
    end

    always_comb begin
        if (r_kind == KIND_RAW) begin
            w_after_sign = S_RAW;
        end else if (r_prefix) begin
            w_after_sign = S_PFX0;
        end else begin
            w_after_sign = S_DIGIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_emit  = 1'b0;
        w_char  = CH_NUL;
        w_last  = 1'b0;
        w_adv   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (t_kind'(i_kind) == KIND_DEC) ? S_CONV : S_SIGN;
                end
            end
            S_CONV: begin
                if (w_bcd_done) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                w_emit = r_neg;
                w_char = CH_MINUS;
                if (!r_neg || w_out_free) begin
                    n_state = w_after_sign;
                end
            end
            S_PFX0: begin
                w_emit = 1'b1;
                w_char = CH_ZERO;
                if (w_out_free) begin
                    n_state = S_PFX1;
                end
            end
            S_PFX1: begin
                w_emit = 1'b1;
                w_char = w_pfx_char;
                if (w_out_free) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                w_emit = w_dig_emit;
                w_char = w_dig_char;
                if (!w_dig_emit || w_out_free) begin
                    w_adv = 1'b1;
                    if (r_pos == w_pos_last) begin
                        n_state = S_NUL;
                    end
                end
            end
            S_RAW: begin
                w_emit = (r_sh[BCD_W-1:16] == '0);
                w_char = r_sh[15:8];
                if (!w_emit || w_out_free) begin
                    n_state = S_NUL;
                end
            end
            S_NUL: begin
                w_emit = 1'b1;
                w_char = CH_NUL;
                w_last = 1'b1;
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_fire = w_emit && w_out_free;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg    <= w_raw[VALUE_W-1];
            r_kind   <= t_kind'(i_kind);
            r_prefix <= i_with_prefix;
            r_sh     <= {w_mag, 8'h00};
            r_pos    <= '0;
            r_seen   <= 1'b0;
        end else if ((r_state == S_CONV) && w_bcd_done) begin
            r_sh <= w_bcd;
        end else if (w_adv) begin
            r_pos  <= r_pos + 1'b1;
            r_seen <= r_seen || w_dig_emit;
            if (r_kind == KIND_BIN) begin
                r_sh <= {r_sh[BCD_W-2:0], 1'b0};
            end else begin
                r_sh <= {r_sh[BCD_W-5:0], 4'h0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_last_is_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> (r_out_char == CH_NUL))
        else $error("last mark on a non-NUL character");
    a_idle_pending_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && r_out_valid |-> r_out_last)
        else $error("idle with a run character still pending");
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_pos <= w_pos_last))
        else $error("digit position out of range");
`endif

endmodule
